FILE: rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

  // Geometry
  localparam int MAP_PAGES  = 4096;
  localparam int PAGE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int ROW_BITS   = 256;
  localparam int ROW_IDX_W  = $clog2(ROW_BITS);
  localparam int ROWS       = MAP_PAGES / ROW_BITS;
  localparam int ROW_AW     = $clog2(ROWS);

  localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MAP_PAGES_C      = CNT_W'(MAP_PAGES);
  localparam logic [CNT_W-1:0] TOTAL_RESET      = CNT_W'(4096);
  localparam logic [CNT_W-1:0] EFF_TOTAL_RESET  =
    (TOTAL_RESET > MAP_PAGES_C) ? MAP_PAGES_C : TOTAL_RESET;

  // Opcodes
  localparam logic [2:0] OP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_LOCK      = 3'd2;
  localparam logic [2:0] OP_RESERVE   = 3'd3;
  localparam logic [2:0] OP_UNRESERVE = 3'd4;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_ALREADY   = 2'd1;
  localparam logic [1:0] ST_NO_FREE   = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [PAGE_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } out_item_t;

  typedef struct packed {
    logic                re;
    logic [ROW_AW-1:0]   raddr;
    logic                we;
    logic [ROW_AW-1:0]   waddr;
    logic [ROW_BITS-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic                 found;
    logic [ROW_IDX_W-1:0] bit_idx;
    logic                 last;
  } scan_res_t;

  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] eff_total;
  } cfg_evt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH
  } state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] clip_total(input logic [CNT_W-1:0] t);
    return (t > MAP_PAGES_C) ? MAP_PAGES_C : t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bpfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpfa_row_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Lowest free page in one bitmap row, limited to pages below the total.
module bpfa_row_scan (
  input  wire logic [bpfa_pkg::ROW_BITS-1:0] row_data_i,
  input  wire logic [bpfa_pkg::ROW_AW-1:0]   row_i,
  input  wire logic [bpfa_pkg::CNT_W-1:0]    eff_total_i,
  output      bpfa_pkg::scan_res_t           res_o
);
  import bpfa_pkg::*;

  logic [CNT_W-1:0]    base;
  logic [CNT_W-1:0]    row_end;
  logic [CNT_W-1:0]    remain;
  logic [ROW_BITS-1:0] mask;
  logic [ROW_BITS-1:0] avail;

  assign base    = CNT_W'({row_i, ROW_IDX_W'(0)});
  assign row_end = base + CNT_W'(ROW_BITS);
  assign remain  = eff_total_i - base;

  always_comb begin
    if (eff_total_i <= base) begin
      mask = '0;
    end else if (eff_total_i >= row_end) begin
      mask = '1;
    end else begin
      mask = (ROW_BITS'(1) << remain[ROW_IDX_W-1:0]) - ROW_BITS'(1);
    end
  end

  assign avail = ~row_data_i & mask;

  always_comb begin
    res_o.found   = |avail;
    res_o.last    = (row_end >= eff_total_i);
    res_o.bit_idx = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        res_o.bit_idx = ROW_IDX_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bpfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: row-by-row scan for requests, read-modify-write for single pages.
module bpfa_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire bpfa_pkg::in_item_t            in_item_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      bpfa_pkg::out_item_t           out_item_o,
  input  wire bpfa_pkg::cfg_evt_t            cfg_evt_i,
  input  wire logic [bpfa_pkg::CNT_W-1:0]    eff_total_i,
  output      bpfa_pkg::ram_req_t            ram_req_o,
  input  wire logic [bpfa_pkg::ROW_BITS-1:0] ram_rdata_i
);
  import bpfa_pkg::*;

  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [PAGE_W-1:0]   idx_q, idx_d;
  logic [ROW_AW-1:0]   row_q, row_d;
  logic [ROWS-1:0]     valid_q, valid_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    rsvd_q, rsvd_d;
  out_item_t           res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] page_mask;
  scan_res_t           scan;
  logic                accept;
  logic                target;
  logic                out_free;

  assign row_data = valid_q[row_q] ? ram_rdata_i : '0;

  bpfa_row_scan u_scan (
    .row_data_i  (row_data),
    .row_i       (row_q),
    .eff_total_i (eff_total_i),
    .res_o       (scan)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign target      = (op_q == OP_LOCK) || (op_q == OP_RESERVE);
  assign page_mask   = ROW_BITS'(1) << idx_q[ROW_IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    row_d       = row_q;
    valid_d     = valid_q;
    free_d      = free_q;
    used_d      = used_q;
    rsvd_d      = rsvd_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_req_o   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = in_item_i.opcode;
          idx_d = in_item_i.page_index;
          if (in_item_i.opcode > OP_UNRESERVE) begin
            // unknown opcode: no effect, report counts
            res_d   = '{ST_DONE, '0, free_q, used_q, rsvd_q};
            state_d = S_PUSH;
          end else begin
            row_d = (in_item_i.opcode == OP_REQUEST) ? '0
                  : in_item_i.page_index[PAGE_W-1 -: ROW_AW];
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = row_d;
            state_d         = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        if (op_q == OP_REQUEST) begin
          if (scan.found) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = row_q;
            ram_req_o.wdata = row_data | (ROW_BITS'(1) << scan.bit_idx);
            valid_d[row_q]  = 1'b1;
            free_d          = sat_dec(free_q);
            used_d          = sat_inc(used_q);
            res_d = '{ST_DONE, {row_q, scan.bit_idx}, free_d, used_d, rsvd_q};
            state_d = S_PUSH;
          end else if (scan.last || (row_q == ROW_AW'(ROWS - 1))) begin
            res_d   = '{ST_NO_FREE, '0, free_q, used_q, rsvd_q};
            state_d = S_PUSH;
          end else begin
            row_d           = row_q + ROW_AW'(1);
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = row_d;
          end
        end else begin
          if ({1'b0, idx_q} >= eff_total_i) begin
            res_d = '{ST_RANGE, '0, free_q, used_q, rsvd_q};
          end else if (row_data[idx_q[ROW_IDX_W-1:0]] == target) begin
            res_d = '{ST_ALREADY, '0, free_q, used_q, rsvd_q};
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = row_q;
            ram_req_o.wdata = target ? (row_data | page_mask) : (row_data & ~page_mask);
            valid_d[row_q]  = 1'b1;
            free_d = target ? sat_dec(free_q) : sat_inc(free_q);
            unique case (op_q)
              OP_FREE:    used_d = sat_dec(used_q);
              OP_LOCK:    used_d = sat_inc(used_q);
              OP_RESERVE: rsvd_d = sat_inc(rsvd_q);
              default:    rsvd_d = sat_dec(rsvd_q);
            endcase
            res_d = '{ST_DONE, '0, free_d, used_d, rsvd_d};
          end
          state_d = S_PUSH;
        end
      end

      S_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // new total: empty map, fresh counts
    if (cfg_evt_i.clear) begin
      valid_d = '0;
      free_d  = cfg_evt_i.eff_total;
      used_d  = '0;
      rsvd_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      free_q      <= EFF_TOTAL_RESET;
      used_q      <= '0;
      rsvd_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      free_q      <= free_d;
      used_q      <= used_d;
      rsvd_q      <= rsvd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    idx_q <= idx_d;
    row_q <= row_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Bitmap page frame allocator, first fit.
// Input channel (in_valid_i / in_stall_o) carries one operation item: request,
// free, lock, reserve or unreserve. Output channel (out_valid_o / out_stall_i)
// returns one result item per operation: status, granted page and the three
// page counts after the operation.
// The bitmap sits in a 16 x 256-bit RAM. A request scans one row per cycle
// through a single lowest-free-bit unit, so it scans 1 to 16 rows; the page
// operations do one read-modify-write of their row, unknown opcodes none.
// One item is in flight at a time: the next is taken only once the result
// of the last one has moved to the output register.
// A finished result waits in an internal register while the output register
// is stalled; the input stays stalled until the result is handed over.
// Reset: all pages free, total 4096, free count = total, other counts zero.
// Rows carry valid bits, so reset and a total_pages write empty the map at
// once. Write total_pages over the cfg channel only when the block is idle.
module bitmap_page_frame_allocator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire bpfa_pkg::in_item_t         in_item_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      bpfa_pkg::out_item_t        out_item_o,
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [bpfa_pkg::CNT_W-1:0] cfg_data_i
);
  import bpfa_pkg::*;

  logic [CNT_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]    eff_total;
  cfg_evt_t            cfg_evt;
  ram_req_t            ram_req;
  logic [ROW_BITS-1:0] ram_rdata;

  // config register is always writable; writes must only arrive while idle, which the block does not enforce
  assign cfg_ready_o       = 1'b1;
  assign cfg_evt.clear     = cfg_valid_i;
  assign cfg_evt.eff_total = clip_total(cfg_data_i);
  assign total_d           = cfg_valid_i ? cfg_data_i : total_q;
  assign eff_total         = clip_total(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else begin
      total_q <= total_d;
    end
  end

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_evt_i   (cfg_evt),
    .eff_total_i (eff_total),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bpfa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: dv/bitmap_page_frame_allocator_test.sv
`timescale 1ns / 1ps

// Testbench for bitmap_page_frame_allocator.
// The bench keeps its own copy of the page map and the three counters.
// Every accepted operation item advances that copy, and the outcome is queued.
// A monitor on the output channel pops the oldest outcome for each result item
// and compares it field by field.
// Directed tests cover the corners first: already-in-state, out of range,
// no free page, unknown opcodes, freeing a reserved page and counter floors.
// Then randomized phases run under several totals.
module bitmap_page_frame_allocator_test;
  import bpfa_pkg::*;

  // opcodes the block does not define; they must pass through as no-ops
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // generous: ~1000 items take well under 1 ms
  localparam int unsigned TIMEOUT_NS   = 5_000_000;
  localparam int          ITEMS_PER_PHASE = 125;
  localparam int          DRAIN_CYCLES = 20;   // outlasts the longest request

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  in_item_t         in_item   = '0;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  bitmap_page_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow: busy bit per page, effective total, three counters
  // ---------------------------------------------------------------------------
  bit               page_taken [MAP_PAGES];
  logic [CNT_W-1:0] managed_pages;
  logic [CNT_W-1:0] n_free;
  logic [CNT_W-1:0] n_used;
  logic [CNT_W-1:0] n_reserved;

  out_item_t        expected_results[$];
  out_item_t        oldest_expected;
  int               mismatch_count = 0;
  int               idle_pct = 0;      // chance per item/cycle to start an idle burst
  int               stall_left = 0;

  // a total write empties the map; totals past the map size clip to it
  function automatic void restart_allocator(input logic [CNT_W-1:0] total);
    managed_pages = (total > MAP_PAGES_C) ? MAP_PAGES_C : total;
    foreach (page_taken[i]) page_taken[i] = 1'b0;
    n_free     = managed_pages;
    n_used     = '0;
    n_reserved = '0;
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  // applies one operation to the shadow and returns the result item it yields
  function automatic out_item_t apply_page_op(input in_item_t op);
    out_item_t r;
    logic      target;
    int        pg;
    r      = '0;
    r.status = ST_DONE;
    pg     = int'(op.page_index);
    case (op.opcode)
      OP_REQUEST: begin
        // first fit: lowest clear bit below the effective total
        r.status = ST_NO_FREE;
        for (int i = 0; i < int'(managed_pages); i++) begin
          if (!page_taken[i]) begin
            page_taken[i]  = 1'b1;
            n_free         = count_down(n_free);
            n_used         = count_up(n_used);
            r.granted_page = PAGE_W'(i);
            r.status       = ST_DONE;
            break;
          end
        end
      end
      OP_FREE, OP_LOCK, OP_RESERVE, OP_UNRESERVE: begin
        if (pg >= int'(managed_pages)) begin
          r.status = ST_RANGE;
        end else begin
          target = (op.opcode == OP_LOCK) || (op.opcode == OP_RESERVE);
          if (page_taken[pg] == target) begin
            r.status = ST_ALREADY;
          end else begin
            // the map cannot tell used from reserved: free/unreserve clear any set bit
            page_taken[pg] = target;
            n_free = target ? count_down(n_free) : count_up(n_free);
            case (op.opcode)
              OP_FREE:    n_used     = count_down(n_used);
              OP_LOCK:    n_used     = count_up(n_used);
              OP_RESERVE: n_reserved = count_up(n_reserved);
              default:    n_reserved = count_down(n_reserved);
            endcase
          end
        end
      end
      default: ;  // unknown opcode: nothing changes, status done
    endcase
    r.free_pages     = n_free;
    r.used_pages     = n_used;
    r.reserved_pages = n_reserved;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the item was taken,
  // possibly after an idle burst with valid low.
  task automatic send_page_op(input logic [2:0] opcode, input logic [PAGE_W-1:0] page);
    in_item_t it;
    it.opcode     = opcode;
    it.page_index = page;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    expected_results.push_back(apply_page_op(it));
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // drop valid and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] total);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= total;
    do @(posedge clk_i); while (!cfg_ready);
    restart_allocator(total);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic: indices land below the total most of the time,
  // requests dominate so small totals fill up and hit the no-free case
  task automatic send_random_op();
    logic [2:0]        opcode;
    logic [PAGE_W-1:0] page;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      opcode = OP_REQUEST;
    else if (pick < 58) opcode = OP_FREE;
    else if (pick < 68) opcode = OP_LOCK;
    else if (pick < 80) opcode = OP_RESERVE;
    else if (pick < 95) opcode = OP_UNRESERVE;
    else                opcode = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
    if (managed_pages != '0 && $urandom_range(0, 9) < 8)
      page = PAGE_W'($urandom_range(0, int'(managed_pages) - 1));
    else
      page = PAGE_W'($urandom);
    send_page_op(opcode, page);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: result checker plus random stall bursts
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with no operation pending: %p", out_item);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("status", int'(oldest_expected.status), int'(out_item.status));
        check_field("granted_page", int'(oldest_expected.granted_page),
                    int'(out_item.granted_page));
        check_field("free_pages", int'(oldest_expected.free_pages),
                    int'(out_item.free_pages));
        check_field("used_pages", int'(oldest_expected.used_pages),
                    int'(out_item.used_pages));
        check_field("reserved_pages", int'(oldest_expected.reserved_pages),
                    int'(out_item.reserved_pages));
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // total 4096 out of reset: first fit, state toggles and no-op opcodes
  task automatic test_after_reset();
    send_page_op(OP_REQUEST, 12'hFFF);   // index ignored, gets page 0
    send_page_op(OP_REQUEST, 12'h000);   // page 1
    send_page_op(OP_FREE, 12'h000);
    send_page_op(OP_FREE, 12'h000);      // already free
    send_page_op(OP_REQUEST, 12'h000);   // page 0 again
    send_page_op(OP_LOCK, 12'hFFF);      // top page
    send_page_op(OP_LOCK, 12'hFFF);      // already used
    send_page_op(OP_RESERVE, 12'hAAA);
    send_page_op(OP_RESERVE, 12'hAAA);   // already set
    send_page_op(OP_UNRESERVE, 12'hAAA);
    send_page_op(OP_UNRESERVE, 12'h555); // already clear
    send_page_op(OP_UNRESERVE, 12'hFFF); // clears a locked page, reserved stays at 0
    for (int op = OP_SPARE_5; op <= OP_SPARE_7; op++)
      send_page_op(3'(op), 12'h555);
  endtask

  // one managed page: fill, no free page, range edge, reserved page freed
  task automatic test_single_page();
    write_total(13'd1);
    send_page_op(OP_REQUEST, 12'h000);
    send_page_op(OP_REQUEST, 12'h000);   // nothing left
    send_page_op(OP_LOCK, 12'h001);      // just past the total
    send_page_op(OP_FREE, 12'h000);
    send_page_op(OP_RESERVE, 12'h000);
    send_page_op(OP_FREE, 12'h000);      // counted as used-to-free, used floors at 0
    send_page_op(OP_REQUEST, 12'h000);
  endtask

  task automatic test_empty_total();
    write_total('0);
    send_page_op(OP_REQUEST, 12'h000);
    send_page_op(OP_FREE, 12'h000);
  endtask

  // largest writable value behaves as the full map
  task automatic test_oversized_total();
    write_total(CNT_MAX);
    send_page_op(OP_LOCK, 12'hFFF);
    send_page_op(OP_REQUEST, 12'h000);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] phase_total [8];
    phase_total = '{MAP_PAGES_C, 13'd8, 13'd37, 13'd2, 13'd257, CNT_MAX, 13'd256, 13'd16};
    phase_total[7] = CNT_W'($urandom_range(2, 64));
    for (int ph = 0; ph < 8; ph++) begin
      write_total(phase_total[ph]);
      // phase 3 and the final phase run without idling
      idle_pct = (ph == 3 || ph == 7) ? 0 : 10 + 5 * ph;
      repeat (ITEMS_PER_PHASE) send_random_op();
    end
  endtask

  initial begin
    restart_allocator(TOTAL_RESET);
    repeat (11) @(posedge clk_i);
    rst_ni   <= 1'b1;
    idle_pct = 20;
    test_after_reset();
    test_single_page();
    test_empty_total();
    test_oversized_total();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: bitmap_page_frame_allocator.f
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_row_scan.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator.sv
dv/bitmap_page_frame_allocator_test.sv
